// ----- rtl/leveled_page_mapping_table_macros.svh -----
// Assertion macros for the leveled page mapping table
`ifndef LEVELED_PAGE_MAPPING_TABLE_MACROS_SVH
`define LEVELED_PAGE_MAPPING_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define LPMT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("lpmt assertion failed");
`define LPMT_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("lpmt assertion failed");
`else
`define LPMT_ASSERT(lbl, clk, rst_n, prop)
`define LPMT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/lpmt_pkg.sv -----
// Types, constants and helpers shared by the page mapping table modules
`timescale 1ns / 1ps
package lpmt_pkg;
	localparam int DEPTH       = 64;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int ADDR_W      = 48;
	localparam int PAGE_SHIFT  = 12;
	localparam int LEVEL_SHIFT = 9;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] virt;
		logic [ADDR_W-1:0] phys;
		logic [3:0]        perm;
		logic [1:0]        kind;
		logic [1:0]        level;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} wr_req_t;

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic              covered;
		logic [ADDR_W-1:0] diff;
	} match_t;

	// bits above the in-page offset that must be zero for the level's page size
	function automatic logic [ADDR_W-1:0] span_mask(input logic [1:0] lvl);
		logic [ADDR_W-1:0] span;
		span = ADDR_W'(1) << (PAGE_SHIFT + LEVEL_SHIFT * int'(lvl));
		return ~(span - ADDR_W'(1));
	endfunction
endpackage

// ----- rtl/lpmt_store.sv -----
// Mapping table memory: one write port, one registered read port
`timescale 1ns / 1ps
module lpmt_store import lpmt_pkg::*; (
	input  logic    clk,
	input  wr_req_t wr,
	input  rd_req_t rd,
	output entry_t  rdata
);
	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.re) begin
			rdata_q <= mem_q[rd.addr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/lpmt_match.sv -----
// Shared range comparator: tests whether an address falls inside one mapping
`timescale 1ns / 1ps
module lpmt_match import lpmt_pkg::*; (
	input  logic [ADDR_W-1:0] va,
	input  entry_t            ent,
	output match_t            res
);
	logic [ADDR_W:0] sub;

	always_comb begin
		sub         = {1'b0, va} - {1'b0, ent.virt};
		res.diff    = sub[ADDR_W-1:0];
		res.covered = !sub[ADDR_W] && ((sub[ADDR_W-1:0] & span_mask(ent.level)) == '0);
	end
endmodule

// ----- rtl/leveled_page_mapping_table.sv -----
// Top level of the leveled page mapping table: sequencer, registers and ports
// Insert, clear and no-op beats finish in the cycle they are accepted and are
// reported from the output register in the next cycle. A lookup walks the table
// from the newest mapping down through the single read port of the mapping
// memory and one shared range comparator, one entry per cycle, stopping at the
// first covering entry; a hit passes through the finish state for the final
// base-plus-offset add. A disabled block or an empty table answers a lookup
// with a miss at once. A new beat is taken when the sequencer is idle and the
// output register is free or being drained.
`timescale 1ns / 1ps
`include "leveled_page_mapping_table_macros.svh"
module leveled_page_mapping_table import lpmt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,  // virt_addr, phys_addr_in, perm_in, kind_in, level_in
	input  logic [1:0]   s_tuser,  // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // translated_addr, found_perm, found_kind, found_level,
	                               // entry_count, zero pad
	output logic [1:0]   m_tuser,  // hit, dropped
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	state_t            state_q;
	logic              enable_q;
	logic [CNT_W-1:0]  fill_cnt_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic              all_issued_q;
	logic              pend_s1;
	logic              last_s1;
	logic [ADDR_W-1:0] va_q;
	logic [ADDR_W-1:0] phys_q;
	logic [ADDR_W-1:0] diff_q;
	logic [3:0]        perm_q;
	logic [1:0]        kind_q;
	logic [1:0]        level_q;

	logic              out_valid_q;
	logic              o_hit_q;
	logic [ADDR_W-1:0] o_addr_q;
	logic [3:0]        o_perm_q;
	logic [1:0]        o_kind_q;
	logic [1:0]        o_level_q;
	logic [CNT_W-1:0]  o_cnt_q;
	logic              o_drop_q;

	mode_t             mode;
	entry_t            in_ent;
	logic              accept;
	logic              room;
	logic              ins_ok;
	logic              start_scan;
	logic              scan_hit;
	logic              scan_miss;
	logic              res_load;
	logic [CNT_W-1:0]  cnt_next;
	logic [CNT_W-1:0]  cnt_dec;
	logic              r_hit;
	logic [ADDR_W-1:0] r_addr;
	logic [3:0]        r_perm;
	logic [1:0]        r_kind;
	logic [1:0]        r_level;
	logic              r_drop;
	wr_req_t           wr;
	rd_req_t           rd;
	entry_t            rdata;
	match_t            mres;
	logic              cfg_wr;

	assign mode         = mode_t'(s_tuser);
	assign in_ent.virt  = s_tdata[47:0];
	assign in_ent.phys  = s_tdata[95:48];
	assign in_ent.perm  = s_tdata[99:96];
	assign in_ent.kind  = s_tdata[101:100];
	assign in_ent.level = s_tdata[103:102];

	assign s_tready   = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept     = s_tvalid && s_tready;
	assign room       = fill_cnt_q < CNT_W'(DEPTH);
	assign ins_ok     = enable_q && room;
	assign start_scan = accept && (mode == MODE_LOOKUP) && enable_q && (fill_cnt_q != '0);
	assign scan_hit   = (state_q == ST_SCAN) && pend_s1 && mres.covered;
	assign scan_miss  = (state_q == ST_SCAN) && pend_s1 && !mres.covered && last_s1;
	assign res_load   = (accept && !start_scan) || scan_miss || (state_q == ST_FIN);
	assign cnt_dec    = fill_cnt_q - CNT_W'(1);

	assign wr.we   = accept && (mode == MODE_INSERT) && ins_ok;
	assign wr.addr = fill_cnt_q[IDX_W-1:0];
	assign wr.data = in_ent;
	assign rd.re   = (state_q == ST_SCAN) && !all_issued_q;
	assign rd.addr = rd_idx_q;

	lpmt_store u_store (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

	lpmt_match u_match (
		.va  (va_q),
		.ent (rdata),
		.res (mres)
	);

	always_comb begin
		cnt_next = fill_cnt_q;
		r_drop   = 1'b0;
		if (accept) begin
			case (mode)
				MODE_INSERT: begin
					if (ins_ok) begin
						cnt_next = fill_cnt_q + CNT_W'(1);
					end else begin
						r_drop = 1'b1;
					end
				end
				MODE_CLEAR: cnt_next = '0;
				default:    cnt_next = fill_cnt_q;
			endcase
		end
		r_hit   = (state_q == ST_FIN);
		r_addr  = r_hit ? (phys_q + diff_q) : '0;
		r_perm  = r_hit ? perm_q : '0;
		r_kind  = r_hit ? kind_q : '0;
		r_level = r_hit ? level_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_cnt_q   <= '0;
			enable_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			pend_s1      <= 1'b0;
			all_issued_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				enable_q <= pwdata[0];
			end
			fill_cnt_q <= cnt_next;
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end
			pend_s1 <= rd.re;
			if (rd.re && (rd_idx_q == '0)) begin
				all_issued_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start_scan) begin
						state_q      <= ST_SCAN;
						all_issued_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (scan_hit) begin
						state_q <= ST_FIN;
					end else if (scan_miss) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FIN:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start_scan) begin
			va_q     <= in_ent.virt;
			rd_idx_q <= cnt_dec[IDX_W-1:0];
		end else if (rd.re) begin
			last_s1 <= (rd_idx_q == '0);
			if (rd_idx_q != '0) begin
				rd_idx_q <= rd_idx_q - IDX_W'(1);
			end
		end
		if (scan_hit) begin
			phys_q  <= rdata.phys;
			diff_q  <= mres.diff;
			perm_q  <= rdata.perm;
			kind_q  <= rdata.kind;
			level_q <= rdata.level;
		end
		if (res_load) begin
			o_hit_q   <= r_hit;
			o_addr_q  <= r_addr;
			o_perm_q  <= r_perm;
			o_kind_q  <= r_kind;
			o_level_q <= r_level;
			o_cnt_q   <= cnt_next;
			o_drop_q  <= r_drop;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, o_cnt_q, o_level_q, o_kind_q, o_perm_q, o_addr_q};
	assign m_tuser  = {o_drop_q, o_hit_q};

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {31'b0, enable_q} : 32'b0;

	`LPMT_ASSERT(a_cnt_bound, clk, arst_n, fill_cnt_q <= CNT_W'(DEPTH))
	`LPMT_ASSERT(a_fin_one_cycle, clk, arst_n, state_q == ST_FIN |=> state_q == ST_IDLE)
	`LPMT_ASSERT(a_scan_idx, clk, arst_n, state_q == ST_SCAN |-> {1'b0, rd_idx_q} < fill_cnt_q)
	`LPMT_ASSERT(a_scan_no_load, clk, arst_n, (state_q == ST_SCAN && !pend_s1) |-> !res_load)
endmodule
